// ===== rtl/core/stack_expression_evaluator_assert.svh =====
// Assertion macros for the stack expression evaluator.
`ifndef STACK_EXPRESSION_EVALUATOR_ASSERT_SVH
`define STACK_EXPRESSION_EVALUATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SEE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SEE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/see_pkg.sv =====
// Shared types, sizes and codes for the stack expression evaluator.
`timescale 1ns / 1ps

package see_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 4;
    localparam int STATUS_W    = 3;

    typedef logic [DATA_W-1:0]   t_word;
    typedef logic [SP_W-1:0]     t_sp;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    // Listed from the top bit down: cmd sits in the lowest bits.
    typedef struct packed {
        logic  fetch_ok;
        t_word operand;
        t_cmd  cmd;
    } t_instr;

    localparam t_cmd OP_FLAG  = 4'd0;
    localparam t_cmd OP_LOAD  = 4'd1;
    localparam t_cmd OP_CONST = 4'd2;
    localparam t_cmd OP_NOT   = 4'd3;
    localparam t_cmd OP_NEG   = 4'd4;
    localparam t_cmd OP_OR    = 4'd5;
    localparam t_cmd OP_AND   = 4'd6;
    localparam t_cmd OP_EQ    = 4'd7;
    localparam t_cmd OP_GT    = 4'd8;
    localparam t_cmd OP_GE    = 4'd9;
    localparam t_cmd OP_LT    = 4'd10;
    localparam t_cmd OP_LE    = 4'd11;
    localparam t_cmd OP_ADD   = 4'd12;

    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_BADOP = 3'd1;
    localparam t_status ST_OVER  = 3'd2;
    localparam t_status ST_UNDER = 3'd3;
    localparam t_status ST_FETCH = 3'd4;
    localparam t_status ST_DEPTH = 3'd5;

endpackage

// ===== rtl/core/see_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module see_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/see_alu.sv =====
// Value unit: push value, unary and binary operator results.
`timescale 1ns / 1ps

module see_alu import see_pkg::*; (
    input  t_cmd  i_cmd,
    input  t_word i_operand,
    input  t_word i_tos,
    input  t_word i_nos,
    output t_word o_result
);

    always_comb begin
        case (i_cmd)
            OP_FLAG:  o_result = t_word'(i_operand != '0);
            OP_LOAD:  o_result = i_operand;
            OP_CONST: o_result = i_operand;
            OP_NOT:   o_result = t_word'(i_tos == '0);
            OP_NEG:   o_result = ~i_tos + t_word'(1);
            OP_OR:    o_result = t_word'((i_nos != '0) || (i_tos != '0));
            OP_AND:   o_result = t_word'((i_nos != '0) && (i_tos != '0));
            OP_EQ:    o_result = t_word'(i_nos == i_tos);
            OP_GT:    o_result = t_word'($signed(i_nos) >  $signed(i_tos));
            OP_GE:    o_result = t_word'($signed(i_nos) >= $signed(i_tos));
            OP_LT:    o_result = t_word'($signed(i_nos) <  $signed(i_tos));
            OP_LE:    o_result = t_word'($signed(i_nos) <= $signed(i_tos));
            OP_ADD:   o_result = i_nos + i_tos;
            default:  o_result = '0;
        endcase
    end

endmodule

// ===== rtl/core/stack_expression_evaluator.sv =====
// Stack expression evaluator: the verdict for a last item is registered.
// Throughput: one item per cycle while not stalled; top two stack entries live
// in registers, deeper ones in a RAM whose next-below entry is prefetched.
// A two-slot output (register plus skid) stalls input only when both hold.
// Synchronous active-low reset clears pointer, error and output valids;
// RAM contents are not cleared (entries are always written before read).
`timescale 1ns / 1ps

module stack_expression_evaluator import see_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // cmd[3:0], operand_value[35:4], fetch_ok[36]
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // status[2:0], truth[3]
);

    t_instr  w_in;
    logic    w_acc;
    logic    w_prod;

    t_sp     r_sp,  n_sp,  e_sp;
    t_status r_err, n_err, e_err;
    t_word   r_tos, e_tos;
    t_word   r_nos, e_nos;
    t_word   r_fwd;
    logic    r_use_fwd;

    logic    w_we;
    t_sp     w_wsub, w_rsub;
    t_word   w_rdata, w_below, w_alu;

    t_status w_status;
    logic    w_truth;

    logic    r_out_valid, r_skid_valid;
    t_status r_out_status, r_skid_status;
    logic    r_out_truth, r_skid_truth;
    logic    w_take;

    assign w_in     = i_s_tdata[36:0];
    assign w_acc    = i_s_tvalid && o_s_tready;
    assign w_prod   = w_acc && i_s_tlast;
    assign w_below  = r_use_fwd ? r_fwd : w_rdata;

    see_alu u_alu (
        .i_cmd     (w_in.cmd),
        .i_operand (w_in.operand),
        .i_tos     (r_tos),
        .i_nos     (r_nos),
        .o_result  (w_alu)
    );

    always_comb begin
        e_sp  = r_sp;
        e_err = r_err;
        e_tos = r_tos;
        e_nos = r_nos;
        w_we  = 1'b0;
        if (w_acc && (r_err == ST_OK)) begin
            if (w_in.cmd > OP_ADD) begin
                e_err = ST_BADOP;
            end else if (w_in.cmd <= OP_CONST) begin
                if ((w_in.cmd != OP_CONST) && !w_in.fetch_ok) begin
                    e_err = ST_FETCH;
                end else if (r_sp == t_sp'(STACK_DEPTH)) begin
                    e_err = ST_OVER;
                end else begin
                    e_tos = w_alu;
                    e_nos = r_tos;
                    e_sp  = r_sp + t_sp'(1);
                    w_we  = (r_sp >= t_sp'(2)) && !i_s_tlast;
                end
            end else if (w_in.cmd <= OP_NEG) begin
                if (r_sp == '0) begin
                    e_err = ST_UNDER;
                end else begin
                    e_tos = w_alu;
                end
            end else begin
                if (r_sp < t_sp'(2)) begin
                    e_err = ST_UNDER;
                end else begin
                    e_tos = w_alu;
                    e_nos = w_below;
                    e_sp  = r_sp - t_sp'(1);
                end
            end
        end
    end

    always_comb begin
        if (e_err != ST_OK) begin
            w_status = e_err;
        end else if (e_sp != t_sp'(1)) begin
            w_status = ST_DEPTH;
        end else begin
            w_status = ST_OK;
        end
        w_truth = (w_status == ST_OK) && (e_tos != '0);
    end

    assign n_sp   = w_prod ? '0 : e_sp;
    assign n_err  = w_prod ? ST_OK : e_err;
    assign w_wsub = r_sp - t_sp'(2);
    assign w_rsub = n_sp - t_sp'(3);

    // Entries below the top two; read address tracks the next pointer.
    see_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wsub[ADDR_W-1:0]),
        .i_wdata (r_nos),
        .i_raddr (w_rsub[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_take     = r_out_valid && i_m_tready;
    assign o_s_tready = !r_skid_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_truth, r_out_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp         <= '0;
            r_err        <= ST_OK;
            r_use_fwd    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_sp      <= n_sp;
            r_err     <= n_err;
            r_use_fwd <= w_we;
            if (r_skid_valid) begin
                if (w_take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (w_prod) begin
                if (r_out_valid && !i_m_tready) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos <= e_tos;
        r_nos <= e_nos;
        if (w_we) begin
            r_fwd <= r_nos;
        end
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_status <= r_skid_status;
                r_out_truth  <= r_skid_truth;
            end
        end else if (w_prod) begin
            if (r_out_valid && !i_m_tready) begin
                r_skid_status <= w_status;
                r_skid_truth  <= w_truth;
            end else begin
                r_out_status <= w_status;
                r_out_truth  <= w_truth;
            end
        end
    end

`include "stack_expression_evaluator_assert.svh"

    `SEE_ASSERT_NOW(a_sp_range, 1'b1, r_sp <= t_sp'(STACK_DEPTH), "stack pointer beyond depth")
    `SEE_ASSERT_NOW(a_skid_order, r_skid_valid, r_out_valid, "skid holds item ahead of output")
    `SEE_ASSERT_NEXT(a_last_clear, w_prod, (r_sp == '0) && (r_err == ST_OK), "no clear after last")
    `SEE_ASSERT_NOW(a_fwd_depth, r_use_fwd, r_sp >= t_sp'(3), "forward without entry below")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the stack expression evaluator: directed table, then random programs.
`timescale 1ns / 1ps

module testbench;
    import see_pkg::*;

    localparam t_cmd OP_UNDEF = 4'd15;

    typedef struct packed {
        t_status st;
        logic    tr;
    } t_verdict;

    typedef struct {
        int unsigned rep;
        t_cmd        cmd;
        t_word       opnd;
        logic        ok;
        logic        lst;
        bit          fixed;
        t_status     st;
        logic        tr;
    } t_row;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;    // cmd[3:0], operand_value[35:4], fetch_ok[36]
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // status[2:0], truth[3]

    t_word       eval_stack [STACK_DEPTH];
    int          eval_depth = 0;
    t_status     eval_err   = ST_OK;
    t_verdict    pending_verdicts [$];
    int          n_fail     = 0;
    int          n_issued   = 0;
    int          snd_idle_pct = 35;
    int          rcv_idle_pct = 55;
    int unsigned hold_req   = 0;

    t_row dir_rows [0:37] = '{
        '{1,  OP_FLAG,  32'h8000_0000, 1'b1, 1'b1, 1'b1, ST_OK,    1'b1},
        '{1,  OP_LOAD,  32'h0000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_CONST, 32'h0000_0005, 1'b0, 1'b1, 1'b1, ST_FETCH, 1'b0},
        '{1,  OP_CONST, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_CONST, 32'h0000_0001, 1'b1, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_ADD,   32'h0000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_NEG,   32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_LOAD,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_LT,    32'h0000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_NOT,   32'h0000_0000, 1'b0, 1'b1, 1'b0, ST_OK,    1'b0},
        '{1,  OP_CONST, 32'h8000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_CONST, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_GT,    32'h0000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_CONST, 32'h0000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_GE,    32'h0000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_CONST, 32'h0000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_LE,    32'h0000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_FLAG,  32'h0000_0000, 1'b1, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_OR,    32'h0000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_CONST, 32'h0000_0003, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_AND,   32'h0000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_CONST, 32'h0000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_EQ,    32'h0000_0000, 1'b0, 1'b1, 1'b0, ST_OK,    1'b0},
        // one push past a full stack
        '{17, OP_CONST, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_OR,    32'h0000_0000, 1'b0, 1'b1, 1'b1, ST_OVER,  1'b0},
        // failed fetch on a full stack wins over overflow
        '{16, OP_CONST, 32'h0000_0001, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_LOAD,  32'h0000_0000, 1'b0, 1'b1, 1'b1, ST_FETCH, 1'b0},
        '{1,  OP_NOT,   32'h0000_0000, 1'b1, 1'b1, 1'b1, ST_UNDER, 1'b0},
        '{1,  OP_CONST, 32'h0000_0001, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_ADD,   32'h0000_0000, 1'b0, 1'b1, 1'b1, ST_UNDER, 1'b0},
        '{1,  OP_UNDEF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_CONST, 32'h0000_0001, 1'b0, 1'b1, 1'b1, ST_BADOP, 1'b0},
        '{1,  OP_CONST, 32'h0000_0001, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_CONST, 32'h0000_0002, 1'b0, 1'b1, 1'b1, ST_DEPTH, 1'b0},
        '{1,  OP_CONST, 32'h8000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_NEG,   32'h0000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_CONST, 32'h8000_0000, 1'b0, 1'b0, 1'b0, ST_OK,    1'b0},
        '{1,  OP_EQ,    32'h0000_0000, 1'b0, 1'b1, 1'b0, ST_OK,    1'b0}
    };

    stack_expression_evaluator u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Runs one instruction on the shadow stack; returns 1 when it yields a verdict.
    function automatic bit evaluate_instr(input t_cmd c, input t_word v, input logic ok,
                                          input logic lst, output t_verdict vd);
        t_word lhs;
        t_word rhs;
        t_word top;
        vd = '0;
        if (eval_err == ST_OK) begin
            if (c > OP_ADD) begin
                eval_err = ST_BADOP;
            end else if (c <= OP_CONST) begin
                if (c != OP_CONST && !ok) begin
                    eval_err = ST_FETCH;
                end else if (eval_depth >= STACK_DEPTH) begin
                    eval_err = ST_OVER;
                end else begin
                    eval_stack[t_addr'(eval_depth)] = (c == OP_FLAG) ? t_word'(v != '0) : v;
                    eval_depth++;
                end
            end else if (c <= OP_NEG) begin
                if (eval_depth < 1) begin
                    eval_err = ST_UNDER;
                end else begin
                    top = eval_stack[t_addr'(eval_depth - 1)];
                    eval_stack[t_addr'(eval_depth - 1)] =
                        (c == OP_NOT) ? t_word'(top == '0) : -top;
                end
            end else if (eval_depth < 2) begin
                eval_err = ST_UNDER;
            end else begin
                rhs = eval_stack[t_addr'(eval_depth - 1)];
                lhs = eval_stack[t_addr'(eval_depth - 2)];
                eval_depth--;
                case (c)
                    OP_OR:   top = t_word'(lhs != '0 || rhs != '0);
                    OP_AND:  top = t_word'(lhs != '0 && rhs != '0);
                    OP_EQ:   top = t_word'(lhs == rhs);
                    OP_GT:   top = t_word'($signed(lhs) >  $signed(rhs));
                    OP_GE:   top = t_word'($signed(lhs) >= $signed(rhs));
                    OP_LT:   top = t_word'($signed(lhs) <  $signed(rhs));
                    OP_LE:   top = t_word'($signed(lhs) <= $signed(rhs));
                    default: top = lhs + rhs;
                endcase
                eval_stack[t_addr'(eval_depth - 1)] = top;
            end
        end
        if (!lst) return 1'b0;
        if (eval_err != ST_OK) begin
            vd.st = eval_err;
        end else if (eval_depth != 1) begin
            vd.st = ST_DEPTH;
        end else begin
            vd.st = ST_OK;
            vd.tr = (eval_stack[0] != '0);
        end
        foreach (eval_stack[i]) eval_stack[i] = '0;
        eval_depth = 0;
        eval_err   = ST_OK;
        return 1'b1;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4:       return t_word'($urandom_range(0, 8)) - 32'd4;
            default: return $urandom;
        endcase
    endfunction

    // Offers one item, waits for acceptance, then records the expected verdict if it is a last item.
    task automatic issue(input t_cmd c, input t_word v, input logic ok, input logic lst,
                         input bit fixed = 1'b0, input t_status fst = ST_OK,
                         input logic ftr = 1'b0);
        t_verdict vd;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, ok, v, c};
        s_tlast  <= lst;
        do @(posedge clk); while (s_tready !== 1'b1);
        n_issued++;
        if (evaluate_instr(c, v, ok, lst, vd)) begin
            if (fixed) begin
                vd.st = fst;
                vd.tr = ftr;
            end
            pending_verdicts.push_back(vd);
        end
    endtask

    task automatic run_program();
        int    kind;
        int    len;
        int    depth;
        int    k;
        t_cmd  c;
        kind  = $urandom_range(0, 99);
        depth = 0;
        if (kind < 75) begin
            // well-formed program, random content
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++) begin
                if (depth < 2 || ($urandom_range(0, 9) < 4 && depth < STACK_DEPTH)) begin
                    issue(t_cmd'($urandom_range(0, 2)), rand_word(),
                          $urandom_range(0, 49) != 0, 1'b0);
                    depth++;
                end else if ($urandom_range(0, 2) == 0) begin
                    issue($urandom_range(0, 1) ? OP_NOT : OP_NEG, rand_word(),
                          1'($urandom_range(0, 1)), 1'b0);
                end else begin
                    issue(t_cmd'($urandom_range(OP_OR, OP_ADD)), rand_word(),
                          1'($urandom_range(0, 1)), 1'b0);
                    depth--;
                end
            end
            while (depth > 2) begin
                issue(t_cmd'($urandom_range(OP_OR, OP_ADD)), rand_word(),
                      1'($urandom_range(0, 1)), 1'b0);
                depth--;
            end
            if (depth == 2)
                c = t_cmd'($urandom_range(OP_OR, OP_ADD));
            else if (depth == 1)
                c = $urandom_range(0, 1) ? OP_NOT : OP_NEG;
            else
                c = t_cmd'($urandom_range(0, 2));
            issue(c, rand_word(), $urandom_range(0, 19) != 0, 1'b1);
        end else if (kind < 90) begin
            // noise
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++)
                issue(t_cmd'($urandom_range(0, 15)), $urandom, 1'($urandom_range(0, 1)),
                      k == len - 1 || $urandom_range(0, 4) == 0);
        end else begin
            // fill the stack to the brim or past it
            len = STACK_DEPTH + $urandom_range(0, 2);
            for (k = 0; k < len; k++)
                issue(t_cmd'($urandom_range(0, 2)), rand_word(), 1'b1, 1'b0);
            issue(t_cmd'($urandom_range(OP_OR, OP_ADD)), rand_word(), 1'b0, 1'b1);
        end
    endtask

    // Result side: checks each accepted item, then picks the next tready.
    initial begin
        t_verdict    want;
        int unsigned hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid === 1'b1 && m_tready) begin
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected item: status %0d truth %0d", m_tdata[2:0], m_tdata[3]);
                    n_fail++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_tdata[2:0] !== want.st) begin
                        $error("status: expected %0d, got %0d", want.st, m_tdata[2:0]);
                        n_fail++;
                    end
                    if (m_tdata[3] !== want.tr) begin
                        $error("truth: expected %0d, got %0d", want.tr, m_tdata[3]);
                        n_fail++;
                    end
                end
            end
            if (hold_req != 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    initial begin
        int w;
        foreach (eval_stack[i]) eval_stack[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            repeat (dir_rows[i].rep)
                issue(dir_rows[i].cmd, dir_rows[i].opnd, dir_rows[i].ok, dir_rows[i].lst,
                      dir_rows[i].fixed, dir_rows[i].st, dir_rows[i].tr);
        end

        while (n_issued < 300) run_program();

        snd_idle_pct = 55;
        rcv_idle_pct = 35;
        while (n_issued < 560) run_program();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        // long receiver stall with the sender pushing one-item programs
        hold_req = 300;
        repeat (24) issue(OP_CONST, rand_word(), 1'($urandom_range(0, 1)), 1'b1);
        while (n_issued < 750) run_program();

        s_tvalid <= 1'b0;
        for (w = 0; w < 20000 && pending_verdicts.size() != 0; w++) @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_verdicts.size() != 0) begin
            $error("%0d expected items never arrived", pending_verdicts.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
